>>> rtl/mfat_pkg.sv
// shared types and constants of the mode finder
package mfat_pkg;

  localparam int VALUE_W    = 32;
  localparam int MCOUNT_W   = 16;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MAX_START,
    S_MAX,
    S_EMIT_START,
    S_EMIT
  } state_t;

endpackage

>>> rtl/mode_finder_all_ties.sv
// mode finder over a set of signed values, reporting every tied mode
//
// usage:
//   in_*  carries one sample per transaction; in_tlast marks the last sample
//         of a set. in_tready is high only while the sequencer is idle.
//   out_* carries one mode per transaction, in order of first appearance;
//         out_tlast marks the final mode of the set, out_tuser the sticky
//         table overflow flag of that set.
// timing:
//   a sample is accepted and then compared with the stored entries in order
//   until one matches or the last is checked; the scan walks the table
//   through the single read port of the entry memory, one entry a cycle.
//   a matching entry is updated in the cycle that finds it; a new value is
//   appended in the same cycle that checks the last entry, or dropped if the table is full.
//   after the last sample of a set, a max pass reads every stored entry and
//   an emit pass walks the entries up to the last tied one.
// reset:
//   clears the entry count, the overflow flag, the sequencer and out_tvalid;
//   table contents are not cleared, only entries below the count are read.
// stall:
//   a finished mode waits in the output register; while it waits and the
//   next tied entry is reached, the emit pass holds on that entry.
module mode_finder_all_ties #(
  parameter int TABLE_DEPTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mfat_pkg::VALUE_W-1:0]        in_tdata,   // [31:0] sample_value
  input  logic                                in_tlast,   // final_sample
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mfat_pkg::OUT_DATA_W-1:0]     out_tdata,  // [31:0] mode_value, [47:32] mode_count
  output logic [0:0]                          out_tuser,  // [0] table_overflowed
  output logic                                out_tlast   // last_mode
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);

  mfat_pkg::state_t state_r, state_nxt;

  // entry memory: one write port, one registered read port
  logic [mfat_pkg::VALUE_W-1:0] value_mem [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]       count_mem [TABLE_DEPTH];
  logic [mfat_pkg::VALUE_W-1:0] rd_val_r;
  logic [COUNT_WIDTH-1:0]       rd_cnt_r;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [mfat_pkg::VALUE_W-1:0] wr_val;
  logic [COUNT_WIDTH-1:0]       wr_cnt;

  // sequencer state
  logic [IDX_W-1:0]             ptr_r, ptr_nxt;
  logic [USED_W-1:0]            used_r, used_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [COUNT_WIDTH-1:0]       best_r, best_nxt;
  logic [IDX_W-1:0]             lastix_r, lastix_nxt;
  logic [mfat_pkg::VALUE_W-1:0] sample_r;
  logic                         final_r;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [mfat_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic                         out_last_r, out_last_nxt;

  logic accept;
  logic scan_end;
  logic hit;
  logic out_free;
  logic emit_match;
  logic emit_load;
  logic table_full;

  assign accept     = in_tvalid && in_tready;
  // rd data always belongs to ptr_r; the last entry is ptr_r == used-1
  assign scan_end   = (used_r == '0) || ((USED_W'(ptr_r) + USED_W'(1)) == used_r);
  assign hit        = (used_r != '0) && (rd_val_r == sample_r);
  assign out_free   = !out_valid_r || out_tready;
  assign emit_match = (rd_cnt_r == best_r);
  assign emit_load  = (state_r == mfat_pkg::S_EMIT) && emit_match && out_free;
  assign table_full = (used_r == USED_W'(TABLE_DEPTH));

  assign in_tready  = (state_r == mfat_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfat_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mfat_pkg::S_SCAN;
      end
      mfat_pkg::S_SCAN: begin
        if (hit || scan_end) begin
          state_nxt = final_r ? mfat_pkg::S_MAX_START : mfat_pkg::S_IDLE;
        end
      end
      mfat_pkg::S_MAX_START: state_nxt = mfat_pkg::S_MAX;
      mfat_pkg::S_MAX: begin
        if (scan_end) state_nxt = mfat_pkg::S_EMIT_START;
      end
      mfat_pkg::S_EMIT_START: state_nxt = mfat_pkg::S_EMIT;
      mfat_pkg::S_EMIT: begin
        if (emit_load && (ptr_r == lastix_r)) state_nxt = mfat_pkg::S_IDLE;
      end
      default: state_nxt = mfat_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ptr_nxt       = ptr_r;
    used_nxt      = used_r;
    ovf_nxt       = ovf_r;
    best_nxt      = best_r;
    lastix_nxt    = lastix_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_val        = sample_r;
    wr_cnt        = COUNT_WIDTH'(1);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      mfat_pkg::S_IDLE: begin
        ptr_nxt = '0;
      end
      mfat_pkg::S_SCAN: begin
        if (hit) begin
          // bump the matching entry, saturating
          wr_en  = 1'b1;
          wr_cnt = (rd_cnt_r == '1) ? rd_cnt_r : rd_cnt_r + COUNT_WIDTH'(1);
        end else if (scan_end) begin
          if (!table_full) begin
            wr_en    = 1'b1;
            wr_addr  = used_r[IDX_W-1:0];
            used_nxt = used_r + USED_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      mfat_pkg::S_MAX_START: begin
        ptr_nxt  = '0;
        best_nxt = '0;
      end
      mfat_pkg::S_MAX: begin
        // keep the highest count and the last entry that holds it
        if (rd_cnt_r >= best_r) begin
          best_nxt   = rd_cnt_r;
          lastix_nxt = ptr_r;
        end
        if (!scan_end) ptr_nxt = ptr_r + IDX_W'(1);
      end
      mfat_pkg::S_EMIT_START: begin
        ptr_nxt = '0;
      end
      mfat_pkg::S_EMIT: begin
        if (emit_match) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {mfat_pkg::MCOUNT_W'(rd_cnt_r), rd_val_r};
            out_ovf_nxt   = ovf_r;
            out_last_nxt  = (ptr_r == lastix_r);
            if (ptr_r == lastix_r) begin
              used_nxt = '0;
              ovf_nxt  = 1'b0;
            end else begin
              ptr_nxt = ptr_r + IDX_W'(1);
            end
          end
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      default: begin
        ptr_nxt = '0;
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= wr_val;
      count_mem[wr_addr] <= wr_cnt;
    end
    rd_val_r <= value_mem[ptr_nxt];
    rd_cnt_r <= count_mem[ptr_nxt];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfat_pkg::S_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    lastix_r   <= lastix_nxt;
    out_data_r <= out_data_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
    if (accept) begin
      sample_r <= in_tdata;
      final_r  <= in_tlast;
    end
  end

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> table_full)
    else $error("overflow flagged with room left in the table");

  a_report_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfat_pkg::S_MAX || state_r == mfat_pkg::S_EMIT) |-> (used_r != '0))
    else $error("report pass over an empty table");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && (ptr_r == lastix_r)) |=>
      (state_r == mfat_pkg::S_IDLE && used_r == '0 && !ovf_r && out_tvalid && out_tlast))
    else $error("set not cleared after final mode");

endmodule

>>> test/testbench.sv
// self-checking testbench for the mode finder: tallies every set and checks each emitted mode

localparam int TALLY_DEPTH = 32;

typedef struct packed {
  logic [31:0] value;
  logic [15:0] count;
  logic        overflowed;
  logic        last;
} mode_rec_t;

// running tally of the current set and the queue of modes it is owed
class mode_tally;
  logic [31:0] entry_val [TALLY_DEPTH];
  logic [15:0] entry_cnt [TALLY_DEPTH];
  int          used;
  bit          dropped;
  mode_rec_t   owed_modes[$];
  int          errors;
  int          modes_predicted;
  int          modes_checked;
  int          sets_closed;
  int          overflow_sets;
  int          widest_tie;

  // counts one accepted sample; on the last sample of a set, queues its modes
  function void add_sample(logic [31:0] v, logic is_last);
    int          i;
    int          hit;
    int          last_idx;
    int          ties;
    logic [15:0] best;
    mode_rec_t   m;
    hit = -1;
    for (i = 0; i < used; i++) begin
      if (hit < 0 && entry_val[i] == v) hit = i;
    end
    if (hit >= 0) begin
      if (entry_cnt[hit] != 16'hffff) entry_cnt[hit] = entry_cnt[hit] + 16'd1;
    end else if (used < TALLY_DEPTH) begin
      entry_val[used] = v;
      entry_cnt[used] = 16'd1;
      used++;
    end else begin
      dropped = 1'b1;
    end
    if (!is_last) return;
    best = '0;
    for (i = 0; i < used; i++) begin
      if (entry_cnt[i] > best) best = entry_cnt[i];
    end
    last_idx = 0;
    ties = 0;
    for (i = 0; i < used; i++) begin
      if (entry_cnt[i] == best) begin
        last_idx = i;
        ties++;
      end
    end
    for (i = 0; i < used; i++) begin
      if (entry_cnt[i] == best) begin
        m.value      = entry_val[i];
        m.count      = entry_cnt[i];
        m.overflowed = dropped;
        m.last       = (i == last_idx);
        owed_modes   = {owed_modes, m};
        modes_predicted++;
      end
    end
    sets_closed++;
    if (dropped) overflow_sets++;
    if (ties > widest_tie) widest_tie = ties;
    used = 0;
    dropped = 1'b0;
  endfunction

  function int outstanding();
    return owed_modes.size();
  endfunction

  // compares one accepted mode against the oldest owed one
  function void check_mode(mode_rec_t got);
    mode_rec_t want;
    if (owed_modes.size() == 0) begin
      $display("%0t: unexpected mode, expected none, got value %0d count %0d ovf %0b last %0b",
               $time, $signed(got.value), got.count, got.overflowed, got.last);
      errors++;
      return;
    end
    want = owed_modes.pop_front();
    modes_checked++;
    if (got.value !== want.value) begin
      $display("%0t: mode_value expected %0d got %0d", $time,
               $signed(want.value), $signed(got.value));
      errors++;
    end
    if (got.count !== want.count) begin
      $display("%0t: mode_count expected %0d got %0d", $time, want.count, got.count);
      errors++;
    end
    if (got.overflowed !== want.overflowed) begin
      $display("%0t: table_overflowed expected %0b got %0b", $time,
               want.overflowed, got.overflowed);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last_mode expected %0b got %0b", $time, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_SAMPLES = 100;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [mfat_pkg::VALUE_W-1:0]    in_tdata   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mfat_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                      out_tuser;
  logic                            out_tlast;

  mode_tally   tally;
  mode_rec_t   got_mode;
  logic [31:0] set_vals[$];
  int          idle_cycles  = 0;
  int          rx_cycle     = 0;
  int          rx_mode      = 0;
  int          burst_left   = 0;
  int          samples_sent = 0;

  // short corner sets: sign extremes, lone samples, ties of two and three
  logic [31:0] dir_vals [20] = '{
    32'h8000_0000,
    32'h7fff_ffff,
    32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
    32'd5, 32'd7, 32'd5, 32'd9, 32'd5,
    32'd1, 32'd2, 32'd3,
    32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
    32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff
  };
  bit dir_last [20] = '{1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 1};

  mode_finder_all_ties #(
    .TABLE_DEPTH(TALLY_DEPTH),
    .COUNT_WIDTH(mfat_pkg::MCOUNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result monitor, receiver stall pattern and idle counter
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_tvalid === 1'b1 && out_tready) begin
        got_mode.value      = out_tdata[31:0];
        got_mode.count      = out_tdata[47:32];
        got_mode.overflowed = out_tuser[0];
        got_mode.last       = out_tlast;
        tally.check_mode(got_mode);
      end
    end
    // stall style, re-picked at random as rx_cycle runs: none, coin flip, 2 of 5, 1 of 16
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_cycle % 5) < 2;
      default: out_tready <= (rx_cycle % 16) == 0;
    endcase
  end

  // gives up when no transaction on either side for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("mode_finder_all_ties: mismatch");
    $finish;
  end

  // one input transaction, with a random gap whenever a burst runs out
  task automatic send_sample(input logic [31:0] v, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= is_last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    tally.add_sample(v, is_last);
    samples_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  initial begin
    int          n;
    int          kind;
    int          k;
    int          sz;
    int          distinct;
    int          random_start;
    logic [31:0] pool [5];
    logic [31:0] base;
    logic [31:0] stride;
    tally = new;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_vals[i]) send_sample(dir_vals[i], dir_last[i]);

    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_SAMPLES) begin
      kind = $urandom_range(0, 11);
      set_vals.delete();
      if (kind <= 5) begin
        // few distinct full-range values, so repeats and ties are common
        k = $urandom_range(1, 5);
        for (n = 0; n < k; n++) pool[n] = $urandom;
        sz = $urandom_range(1, 10);
        for (n = 0; n < sz; n++) set_vals = {set_vals, pool[$urandom_range(0, k - 1)]};
      end else if (kind <= 8) begin
        // values around zero
        sz = $urandom_range(1, 8);
        for (n = 0; n < sz; n++) set_vals = {set_vals, int'($urandom_range(0, 4)) - 2};
      end else if (kind <= 10) begin
        // near or past a full table, then repeats and maybe one more new value
        distinct = $urandom_range(30, 36);
        base     = $urandom;
        stride   = $urandom | 32'd1;
        for (n = 0; n < distinct; n++) set_vals = {set_vals, base + n * stride};
        sz = $urandom_range(0, 5);
        for (n = 0; n < sz; n++)
          set_vals = {set_vals, set_vals[$urandom_range(0, distinct - 1)]};
        if ($urandom_range(0, 1)) set_vals = {set_vals, base + distinct * stride};
      end else begin
        set_vals = {set_vals, $urandom};
      end
      foreach (set_vals[i]) send_sample(set_vals[i], i == set_vals.size() - 1);
    end
    in_tvalid <= 1'b0;

    while (tally.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d sets, %0d samples and %0d checked modes",
             tally.sets_closed, samples_sent, tally.modes_checked);
    $display("%0d sets dropped values on a full table, widest tie %0d modes",
             tally.overflow_sets, tally.widest_tie);
    if (tally.errors == 0)
      $display("mode_finder_all_ties: match");
    else
      $display("mode_finder_all_ties: mismatch");
    $finish;
  end

endmodule
